// ===== rtl/btil_pkg.sv =====
// Shared constants, payload types and controller/datapath bundles for the table interpolator.
package btil_pkg;

    localparam int MAX_SLIP_POINTS_DEF     = 1024;
    localparam int MAX_FRACTION_POINTS_DEF = 256;

    localparam int SLIP_USED_RESET = 1001;
    localparam int FRAC_USED_RESET = 201;

    localparam int CFG_W      = 11;
    localparam int SLIP_CFG_W = 11;
    localparam int FRAC_CFG_W = 9;

    localparam logic CFG_SLIP_USED = 1'b0;
    localparam logic CFG_FRAC_USED = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Interpolation pass select
    localparam logic [1:0] LSEL_LO    = 2'd0;
    localparam logic [1:0] LSEL_HI    = 2'd1;
    localparam logic [1:0] LSEL_FINAL = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [9:0]         row_index;
        logic [7:0]         column_index;
        logic signed [31:0] slip_grid_value;
        logic [16:0]        fraction_grid_value;
        logic signed [31:0] factor_value;
        logic signed [31:0] gas_velocity;
        logic signed [31:0] solid_velocity;
        logic [16:0]        gas_fraction;
    } t_in_item;

    typedef struct packed {
        logic [16:0] correction_factor;
        logic        interpolated;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       capture;
        logic       slip_fix;
        logic       check_lo;
        logic       step;
        logic       lock_lo;
        logic       span;
        logic       tread;
        logic [1:0] tsel;
        logic       lstart;
        logic [1:0] lsel;
        logic       emit;
        logic       emit_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic range_ok;
        logic scan_more;
        logic at_last;
        logic lerp_done;
        logic out_full;
    } t_dp_status;

endpackage

// ===== rtl/btil_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
interface btil_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bilinear_table_interp_log_axis_unit.sv =====
// Top level of the bilinear table interpolator: controller plus datapath.
//
//   channel  direction  transaction carries
//   i_in     sink       load (row, column, axis points, factor) or query (velocities, fraction)
//   o_out    source     correction factor and interpolated flag, one per query
//   i_cfg_*  write      slip / voidage point counts
//
// A load is written in the cycle it is accepted. A query that is interpolated
// steps down from the top of both axes together through the registered axis
// memory read, then fetches four corners; three serial interpolation passes
// on one shared multiply/divide unit follow. A query outside the grid skips
// the scan and the passes. No clearing pass after reset. A result waiting on
// o_out holds the next query in its final state; loads still flow.
module bilinear_table_interp_log_axis_unit #(
    parameter int MAX_SLIP_POINTS     = btil_pkg::MAX_SLIP_POINTS_DEF,
    parameter int MAX_FRACTION_POINTS = btil_pkg::MAX_FRACTION_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [btil_pkg::CFG_W-1:0] i_cfg_data,
    btil_stream_if.sink                i_in,
    btil_stream_if.source              o_out
);
    import btil_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_in_item   in_item;
    t_out_item  out_item;

    assign in_item       = i_in.payload;
    assign o_out.payload = out_item;

    // Sequence each transaction
    btil_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (in_item.opcode),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Hold the tables and do the arithmetic
    btil_dp #(
        .MAX_SLIP_POINTS     (MAX_SLIP_POINTS),
        .MAX_FRACTION_POINTS (MAX_FRACTION_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );
endmodule

// ===== rtl/btil_lerp.sv =====
// Serial linear interpolation unit: a + trunc((b - a) * w / d) with w < d.
module btil_lerp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic [31:0]        i_w,
    input  logic [31:0]        i_d,
    output logic               o_done,
    output logic signed [31:0] o_res
);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_END  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic signed [31:0] r_a;
    logic [31:0]        r_w;
    logic [31:0]        r_d;
    logic [31:0]        r_rem;
    logic [31:0]        r_low;
    logic               r_done;
    logic signed [31:0] r_res;

    logic signed [32:0] diff;
    logic [63:0]        prod;
    logic [32:0]        rem_sh;
    logic               ge;
    logic signed [33:0] sum;

    assign diff   = 33'(i_b) - 33'(i_a);
    assign prod   = 64'(r_mag) * 64'(r_w);
    assign rem_sh = {r_rem, r_low[31]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign sum    = r_neg ? 34'(r_a) - $signed({2'b00, r_low})
                          : 34'(r_a) + $signed({2'b00, r_low});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = L_MUL;
            L_MUL:  n_state = L_DIV;
            L_DIV:  if (r_cnt == 5'd31) n_state = L_END;
            L_END:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_neg <= diff[32];
            r_mag <= diff[32] ? 32'(-diff) : 32'(diff);
            r_a   <= i_a;
            r_w   <= i_w;
            r_d   <= i_d;
        end
        if (r_state == L_MUL) begin
            // high half is below d since the quotient fits 32 bits
            r_rem <= prod[63:32];
            r_low <= prod[31:0];
            r_cnt <= 5'd0;
        end
        if (r_state == L_DIV) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_d}) : rem_sh[31:0];
            r_low <= {r_low[30:0], ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (r_state == L_END) begin
            r_res <= 32'(sum);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== rtl/btil_dp.sv =====
// Datapath: axis and table memories, slip product, axis scan, interpolation and result register.
module btil_dp #(
    parameter int MAX_SLIP_POINTS     = btil_pkg::MAX_SLIP_POINTS_DEF,
    parameter int MAX_FRACTION_POINTS = btil_pkg::MAX_FRACTION_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [btil_pkg::CFG_W-1:0]   i_cfg_data,
    input  btil_pkg::t_in_item           i_item,
    input  btil_pkg::t_dp_cmd            i_cmd,
    output btil_pkg::t_dp_status         o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output btil_pkg::t_out_item          o_out_item
);
    import btil_pkg::*;

    localparam int SW  = $clog2(MAX_SLIP_POINTS);
    localparam int FW  = $clog2(MAX_FRACTION_POINTS);
    localparam int TD  = MAX_SLIP_POINTS * MAX_FRACTION_POINTS;
    localparam int TW  = $clog2(TD);
    localparam int NSW = $clog2(MAX_SLIP_POINTS + 1);
    localparam int NFW = $clog2(MAX_FRACTION_POINTS + 1);
    localparam logic [NSW-1:0] NS_RST =
        NSW'((SLIP_USED_RESET > MAX_SLIP_POINTS) ? MAX_SLIP_POINTS : SLIP_USED_RESET);
    localparam logic [NFW-1:0] NF_RST =
        NFW'((FRAC_USED_RESET > MAX_FRACTION_POINTS) ? MAX_FRACTION_POINTS : FRAC_USED_RESET);

    logic signed [31:0] smem [MAX_SLIP_POINTS];
    logic [16:0]        fmem [MAX_FRACTION_POINTS];
    logic signed [31:0] tmem [TD];

    logic [NSW-1:0]     r_ns, ns_wr;
    logic [NFW-1:0]     r_nf, nf_wr;
    logic signed [50:0] r_prod;
    logic signed [34:0] r_slip;
    logic [16:0]        r_frac;
    logic [SW-1:0]      r_i, r_ilo;
    logic [FW-1:0]      r_j, r_jlo;
    logic signed [31:0] r_sdat, r_slo;
    logic [16:0]        r_fdat, r_flo;
    logic               r_lo_ok;
    logic [31:0]        r_ws, r_ds;
    logic [16:0]        r_wf, r_df;
    logic signed [31:0] r_tdat;
    logic               r_tread_d;
    logic [1:0]         r_tsel_d;
    logic signed [31:0] r_corner [4];
    logic [1:0]         r_lsel_d;
    logic signed [31:0] r_lo, r_hi, r_res;
    logic               r_ovalid;
    t_out_item          r_oitem;

    logic [31:0]        row_ext, col_ext;
    logic               ld_ok;
    logic [SW-1:0]      w_row;
    logic [FW-1:0]      w_col;
    logic [TW-1:0]      w_taddr, rd_taddr;
    logic [SW-1:0]      rd_row;
    logic [FW-1:0]      rd_col;
    logic signed [32:0] vdiff;
    logic signed [50:0] padj;
    logic signed [34:0] sdat_x, slo_x;
    logic               go_i, go_j;
    logic signed [31:0] la, lb, lres;
    logic [31:0]        lw, ld;
    logic               ldone;
    logic               res_ok;

    // Register writes, clamped to the legal point counts
    always_comb begin
        if (i_cfg_data[SLIP_CFG_W-1:0] < SLIP_CFG_W'(2)) begin
            ns_wr = NSW'(2);
        end else if (32'(i_cfg_data[SLIP_CFG_W-1:0]) > 32'(MAX_SLIP_POINTS)) begin
            ns_wr = NSW'(MAX_SLIP_POINTS);
        end else begin
            ns_wr = NSW'(i_cfg_data[SLIP_CFG_W-1:0]);
        end
        if (i_cfg_data[FRAC_CFG_W-1:0] < FRAC_CFG_W'(2)) begin
            nf_wr = NFW'(2);
        end else if (32'(i_cfg_data[FRAC_CFG_W-1:0]) > 32'(MAX_FRACTION_POINTS)) begin
            nf_wr = NFW'(MAX_FRACTION_POINTS);
        end else begin
            nf_wr = NFW'(i_cfg_data[FRAC_CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns <= NS_RST;
            r_nf <= NF_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SLIP_USED) r_ns <= ns_wr;
            else                              r_nf <= nf_wr;
        end
    end

    // Load addressing; drop loads beyond the memories
    assign row_ext = 32'(i_item.row_index);
    assign col_ext = 32'(i_item.column_index);
    assign ld_ok   = (row_ext < 32'(MAX_SLIP_POINTS)) && (col_ext < 32'(MAX_FRACTION_POINTS));
    assign w_row   = row_ext[SW-1:0];
    assign w_col   = col_ext[FW-1:0];
    assign w_taddr = TW'(32'(w_row) * 32'(MAX_FRACTION_POINTS) + 32'(w_col));

    assign rd_row   = r_ilo + SW'(i_cmd.tsel[1]);
    assign rd_col   = r_jlo + FW'(i_cmd.tsel[0]);
    assign rd_taddr = TW'(32'(rd_row) * 32'(MAX_FRACTION_POINTS) + 32'(rd_col));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ld_ok) begin
            smem[w_row]   <= i_item.slip_grid_value;
            fmem[w_col]   <= i_item.fraction_grid_value;
            tmem[w_taddr] <= i_item.factor_value;
        end
        r_sdat <= smem[r_i];
        r_fdat <= fmem[r_j];
        r_tdat <= tmem[rd_taddr];
    end

    // Slip product and axis scan
    assign vdiff  = 33'(i_item.gas_velocity) - 33'(i_item.solid_velocity);
    assign padj   = r_prod[50] ? r_prod + 51'sd65535 : r_prod;
    assign sdat_x = 35'(r_sdat);
    assign slo_x  = 35'(r_slo);
    assign go_i   = (r_i != '0) && (sdat_x > r_slip);
    assign go_j   = (r_j != '0) && (r_fdat > r_frac);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= 51'(vdiff) * 51'($signed({1'b0, i_item.gas_fraction}));
            r_frac <= i_item.gas_fraction;
            r_i    <= '0;
            r_j    <= '0;
        end
        if (i_cmd.slip_fix) begin
            r_slip <= 35'(padj >>> 16);
        end
        if (i_cmd.check_lo) begin
            r_lo_ok <= (r_frac >= r_fdat) && (r_slip >= sdat_x);
            r_i     <= SW'(r_ns - NSW'(1));
            r_j     <= FW'(r_nf - NFW'(1));
        end
        if (i_cmd.step) begin
            if (go_i) r_i <= r_i - SW'(1);
            if (go_j) r_j <= r_j - FW'(1);
        end
        if (i_cmd.lock_lo) begin
            r_slo <= r_sdat;
            r_flo <= r_fdat;
            r_ilo <= r_i;
            r_jlo <= r_j;
            r_i   <= r_i + SW'(1);
            r_j   <= r_j + FW'(1);
        end
        if (i_cmd.span) begin
            r_ws <= 32'(r_slip - slo_x);
            r_ds <= 32'(sdat_x - slo_x);
            r_wf <= r_frac - r_flo;
            r_df <= r_fdat - r_flo;
        end
    end

    assign o_status.range_ok  = r_lo_ok && (r_frac <= r_fdat) && (r_slip <= sdat_x);
    assign o_status.scan_more = go_i || go_j;
    assign o_status.at_last   = (32'(r_i) == 32'(r_ns) - 32'd1) ||
                                (32'(r_j) == 32'(r_nf) - 32'd1);

    // Corner fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tread_d <= 1'b0;
        end else begin
            r_tread_d <= i_cmd.tread;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsel_d <= i_cmd.tsel;
        if (r_tread_d) r_corner[r_tsel_d] <= r_tdat;
    end

    // Interpolation passes share one unit
    always_comb begin
        unique case (i_cmd.lsel)
            LSEL_LO: begin
                la = r_corner[0]; lb = r_corner[1]; lw = 32'(r_wf); ld = 32'(r_df);
            end
            LSEL_HI: begin
                la = r_corner[2]; lb = r_corner[3]; lw = 32'(r_wf); ld = 32'(r_df);
            end
            default: begin
                la = r_lo; lb = r_hi; lw = r_ws; ld = r_ds;
            end
        endcase
    end

    btil_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lstart),
        .i_a     (la),
        .i_b     (lb),
        .i_w     (lw),
        .i_d     (ld),
        .o_done  (ldone),
        .o_res   (lres)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lstart) r_lsel_d <= i_cmd.lsel;
        if (ldone) begin
            unique case (r_lsel_d)
                LSEL_LO: r_lo  <= lres;
                LSEL_HI: r_hi  <= lres;
                default: r_res <= lres;
            endcase
        end
    end

    assign o_status.lerp_done = ldone;

    // Result register
    assign res_ok = i_cmd.emit_ok && (r_res > 32'sd0) && (r_res <= 32'sd65536);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oitem.correction_factor <= res_ok ? 17'(r_res) : ONE_Q16;
            r_oitem.interpolated      <= res_ok;
        end
    end

    assign o_status.out_full = r_ovalid;
    assign o_out_valid       = r_ovalid;
    assign o_out_item        = r_oitem;
endmodule

// ===== rtl/btil_ctrl.sv =====
// Controller: sequences a query through range check, axis scan, corner fetch and three passes.
module btil_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_opcode,
    output logic                 o_in_ready,
    output btil_pkg::t_dp_cmd    o_cmd,
    input  btil_pkg::t_dp_status i_status
);
    import btil_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SLIP    = 4'd1;
    localparam logic [3:0] S_LOW     = 4'd2;
    localparam logic [3:0] S_HWAIT   = 4'd3;
    localparam logic [3:0] S_HIGH    = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_SWAIT   = 4'd6;
    localparam logic [3:0] S_EWAIT   = 4'd7;
    localparam logic [3:0] S_SPAN    = 4'd8;
    localparam logic [3:0] S_TREAD   = 4'd9;
    localparam logic [3:0] S_LSTART  = 4'd10;
    localparam logic [3:0] S_LWAIT   = 4'd11;
    localparam logic [3:0] S_FIN_FB  = 4'd12;
    localparam logic [3:0] S_FIN_TAB = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.tsel = r_cnt[1:0];
        o_cmd.lsel = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load    = accept && (i_in_opcode == OP_LOAD);
                o_cmd.capture = accept && (i_in_opcode == OP_QUERY);
                if (o_cmd.capture) n_state = S_SLIP;
            end
            S_SLIP: begin
                o_cmd.slip_fix = 1'b1;
                n_state        = S_LOW;
            end
            S_LOW: begin
                o_cmd.check_lo = 1'b1;
                n_state        = S_HWAIT;
            end
            S_HWAIT: n_state = S_HIGH;
            S_HIGH: begin
                n_state = i_status.range_ok ? S_SCAN : S_FIN_FB;
            end
            S_SCAN: begin
                if (i_status.scan_more) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SWAIT;
                end else if (i_status.at_last) begin
                    n_state = S_FIN_FB;
                end else begin
                    o_cmd.lock_lo = 1'b1;
                    n_state       = S_EWAIT;
                end
            end
            S_SWAIT: n_state = S_SCAN;
            S_EWAIT: n_state = S_SPAN;
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_cnt      = 3'd0;
                n_state    = S_TREAD;
            end
            S_TREAD: begin
                // issue four corners; the extra step lets the last pass r_tdat into r_corner
                o_cmd.tread = (r_cnt != 3'd4);
                n_cnt       = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_cnt   = 3'd0;
                    n_state = S_LSTART;
                end
            end
            S_LSTART: begin
                o_cmd.lstart = 1'b1;
                n_state      = S_LWAIT;
            end
            S_LWAIT: begin
                if (i_status.lerp_done) begin
                    if (r_cnt[1:0] == LSEL_FINAL) begin
                        n_state = S_FIN_TAB;
                    end else begin
                        n_cnt   = r_cnt + 3'd1;
                        n_state = S_LSTART;
                    end
                end
            end
            S_FIN_FB, S_FIN_TAB: begin
                if (!i_status.out_full) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_ok = (r_state == S_FIN_TAB);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the bilinear table interpolator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btil_pkg::*;

    localparam int SLIP_DEPTH  = MAX_SLIP_POINTS_DEF;
    localparam int FRAC_DEPTH  = MAX_FRACTION_POINTS_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 650;
    localparam int CALM_AFTER  = 550;
    localparam int SETTLE      = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    btil_stream_if #(.T_PAYLOAD(t_in_item))  in_ch ();
    btil_stream_if #(.T_PAYLOAD(t_out_item)) out_ch ();

    bilinear_table_interp_log_axis_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block state, kept in step with every transaction
    // ------------------------------------------------------------------
    logic signed [31:0] slip_pts [SLIP_DEPTH];
    logic [16:0]        frac_pts [FRAC_DEPTH];
    logic signed [31:0] factor_cells [SLIP_DEPTH*FRAC_DEPTH];
    int unsigned        slip_used;
    int unsigned        frac_used;

    t_out_item          pending_factors [$];
    int                 errors;
    int                 items_sent;
    int                 queries_sent;
    int                 interp_seen;
    int                 fallback_seen;
    int                 grids_built;
    int                 idle_cycles;
    bit                 calm;
    int                 stall_left;

    // Clock: 4 ns period
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_points(int unsigned v, int unsigned top);
        if (v < 2) return 2;
        if (v > top) return top;
        return v;
    endfunction

    // a + trunc((b - a) * w / d); the product wraps at 64 bits like the block's datapath
    function automatic longint blend(longint a, longint b, bit [63:0] w, bit [63:0] d);
        longint    diff;
        bit [63:0] q;
        diff = b - a;
        if (diff >= 0) begin
            q = ($unsigned(diff) * w) / d;
            return a + longint'(q);
        end
        q = ($unsigned(-diff) * w) / d;
        return a - longint'(q);
    endfunction

    function automatic longint cell_at(int unsigned row, int unsigned col);
        return longint'(factor_cells[row*FRAC_DEPTH + col]);
    endfunction

    function automatic t_out_item predict_factor(t_in_item it);
        t_out_item   res;
        longint      gas, solid, fr, slip, lo, hi, r;
        int unsigned i, j;
        bit [63:0]   wf, df, ws, ds;
        res.correction_factor = ONE_Q16;
        res.interpolated      = 1'b0;
        gas   = longint'(it.gas_velocity);
        solid = longint'(it.solid_velocity);
        fr    = longint'({47'b0, it.gas_fraction});
        slip  = ((gas - solid) * fr) / 65536;
        if (fr >= longint'({47'b0, frac_pts[0]}) &&
            fr <= longint'({47'b0, frac_pts[frac_used-1]}) &&
            slip >= longint'(slip_pts[0]) && slip <= longint'(slip_pts[slip_used-1])) begin
            i = slip_used - 1;
            j = frac_used - 1;
            while (i > 0 && longint'(slip_pts[i]) > slip) i--;
            while (j > 0 && longint'({47'b0, frac_pts[j]}) > fr) j--;
            if (i < slip_used - 1 && j < frac_used - 1) begin
                wf = $unsigned(fr - longint'({47'b0, frac_pts[j]}));
                df = $unsigned(longint'({47'b0, frac_pts[j+1]}) -
                               longint'({47'b0, frac_pts[j]}));
                ws = $unsigned(slip - longint'(slip_pts[i]));
                ds = $unsigned(longint'(slip_pts[i+1]) - longint'(slip_pts[i]));
                lo = blend(cell_at(i, j), cell_at(i, j+1), wf, df);
                hi = blend(cell_at(i+1, j), cell_at(i+1, j+1), wf, df);
                r  = blend(lo, hi, ws, ds);
                if (r > 0 && r <= 65536) begin
                    res.correction_factor = r[16:0];
                    res.interpolated      = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Apply one accepted transaction to the shadow state
    function automatic void absorb_item(t_in_item it);
        if (it.opcode == OP_LOAD) begin
            slip_pts[it.row_index]    = it.slip_grid_value;
            frac_pts[it.column_index] = it.fraction_grid_value;
            factor_cells[int'(it.row_index)*FRAC_DEPTH + int'(it.column_index)] =
                it.factor_value;
        end else begin
            pending_factors.push_back(predict_factor(it));
            queries_sent++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Random filler for every field; callers overwrite what matters
    function automatic t_in_item noise_item();
        t_in_item it;
        it.opcode              = 1'($urandom);
        it.row_index           = 10'($urandom);
        it.column_index        = 8'($urandom);
        it.slip_grid_value     = $urandom;
        it.fraction_grid_value = 17'($urandom_range(0, 65536));
        it.factor_value        = $urandom;
        it.gas_velocity        = $urandom;
        it.solid_velocity      = $urandom;
        it.gas_fraction        = 17'($urandom_range(0, 65536));
        return it;
    endfunction

    // Send one transaction; valid stays high afterwards so back-to-back
    // items never drop and re-raise valid in the same step
    task automatic send_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        absorb_item(it);
        items_sent++;
        if (items_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_load(int row, int col, logic signed [31:0] sv, logic [16:0] fv,
                             logic signed [31:0] fac);
        t_in_item it;
        it                     = noise_item();
        it.opcode              = OP_LOAD;
        it.row_index           = row[9:0];
        it.column_index        = col[7:0];
        it.slip_grid_value     = sv;
        it.fraction_grid_value = fv;
        it.factor_value        = fac;
        send_item(it);
    endtask

    task automatic send_query(longint gas, longint solid, int fr);
        t_in_item it;
        it                = noise_item();
        it.opcode         = OP_QUERY;
        it.gas_velocity   = gas[31:0];
        it.solid_velocity = solid[31:0];
        it.gas_fraction   = fr[16:0];
        send_item(it);
    endtask

    // Hold until every expected result is back, then let the block settle
    task automatic drain_results();
        release_input();
        while (pending_factors.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SLIP_USED) slip_used = clamp_points(val & 11'h7FF, SLIP_DEPTH);
        else                      frac_used = clamp_points(val & 9'h1FF, FRAC_DEPTH);
    endtask

    // Pick velocities whose slip lands near the target at this fraction
    task automatic query_at(longint target, int fr);
        longint diff, solid, gas;
        diff  = (fr == 0) ? 0 : (target * 65536) / fr;
        solid = -(diff / 2) + longint'($urandom_range(0, 1000)) - 500;
        gas   = solid + diff;
        if (gas > 64'sd2147483647)    gas = 64'sd2147483647;
        if (gas < -64'sd2147483648)   gas = -64'sd2147483648;
        if (solid > 64'sd2147483647)  solid = 64'sd2147483647;
        if (solid < -64'sd2147483648) solid = -64'sd2147483648;
        send_query(gas, solid, fr);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset counts: only the axis end points exist, so ask outside the grid
    task automatic test_reset_counts();
        send_load(0, 0, -32'sd65536000, 17'd1000, 32'sd30000);
        send_load(SLIP_USED_RESET-1, FRAC_USED_RESET-1, 32'sd65536000, 17'd60000, 32'sd30000);
        query_at(0, 500);                           // fraction below the axis
        query_at(0, 65536);                         // fraction above the axis
        send_query(32'sh7FFFFFFF, 32'sh80000000, 30000); // slip far above
        drain_results();
    endtask

    // Low-clamped counts: a 2 x 2 grid built from the field extremes
    task automatic test_min_grid();
        write_reg(CFG_SLIP_USED, 0);
        write_reg(CFG_FRAC_USED, 0);
        send_load(0, 0, 32'sh80000000, 17'd0,     32'sd65536);
        send_load(0, 1, 32'sh80000000, 17'd65536, 32'sd0);
        send_load(1, 0, 32'sh7FFFFFFF, 17'd0,     32'sd40000);
        send_load(1, 1, 32'sh7FFFFFFF, 17'd65536, 32'sd20000);
        send_query(32'sd0, 32'sd0, 0);              // first column exactly, slip mid-cell
        send_query(32'sd100000, 32'sd0, 32768);     // inside the cell
        send_query(32'sh7FFFFFFF, 32'sd0, 65536);   // last row and column
        send_query(-32'sd500000, 32'sd0, 65536);    // last column only
        send_query(32'sh7FFFFFFF, 32'sh80000000, 40000);
        send_query(32'sh80000000, 32'sh7FFFFFFF, 65536);
        drain_results();
    endtask

    // High-clamped counts: end points only, so stay outside or on the top corner
    task automatic test_max_counts();
        write_reg(CFG_SLIP_USED, 11'h7FF);
        write_reg(CFG_FRAC_USED, 9'h1FF);
        send_load(0, 0, -32'sd65536000, 17'd100, 32'sd1);
        send_load(SLIP_DEPTH-1, FRAC_DEPTH-1, 32'sd65536000, 17'd65536, 32'sd1);
        send_query(32'sd65536000, 32'sd0, 65536);  // exactly the top corner
        query_at(0, 50);
        send_query(-32'sd70000000, 32'sd70000000, 65536);
        send_query(32'sd70000000, -32'sd70000000, 65536);
        drain_results();
    endtask

    // Random grids with well-formed queries, plus noise and stray loads
    task automatic test_random_grids();
        logic signed [31:0] sv [16];
        logic [16:0]        fv [16];
        longint             s, smin, smax;
        int                 ns, nf, step, fmin, fmax, nq, sel;
        bit                 shuffled, paused;
        paused = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            ns = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
            nf = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
            write_reg(CFG_SLIP_USED, ns);
            write_reg(CFG_FRAC_USED, nf);
            shuffled = ($urandom_range(0, 4) == 0);
            s = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            for (int r = 0; r < ns; r++) begin
                sv[r] = shuffled ? 32'(s + $urandom_range(0, 1 << 22)) : s[31:0];
                s += $urandom_range(1, 1 << 20);
            end
            step = $urandom_range(1, (65536 - 2000) / (nf - 1));
            fmin = $urandom_range(0, 2000);
            for (int c = 0; c < nf; c++)
                fv[c] = shuffled ? 17'($urandom_range(0, 65536)) : 17'(fmin + c * step);
            for (int r = 0; r < ns; r++)
                for (int c = 0; c < nf; c++)
                    send_load(r, c, sv[r], fv[c], ($urandom_range(0, 9) == 0) ?
                              32'($urandom) : 32'($urandom_range(0, 72000)) - 32'sd3000);
            smin = sv[0]; smax = sv[0];
            for (int r = 1; r < ns; r++) begin
                if (sv[r] < smin) smin = sv[r];
                if (sv[r] > smax) smax = sv[r];
            end
            fmin = fv[0]; fmax = fv[0];
            for (int c = 1; c < nf; c++) begin
                if (fv[c] < fmin) fmin = fv[c];
                if (fv[c] > fmax) fmax = fv[c];
            end
            if (fmin == 0) fmin = 1;
            if (fmax < fmin) fmax = fmin;
            nq = $urandom_range(8, 20);
            for (int q = 0; q < nq; q++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    query_at(smin + longint'($urandom_range(0, 32'(smax - smin))),
                             $urandom_range(fmin, fmax));
                else if (sel < 8)
                    query_at(sv[$urandom_range(0, ns-1)], fv[$urandom_range(0, nf-1)]);
                else if (sel == 8)
                    send_query(32'($urandom), 32'($urandom), $urandom_range(0, 65536));
                else
                    // stray load beyond the rows in use; the table stays consistent
                    send_load($urandom_range(ns, SLIP_DEPTH-1), $urandom_range(0, FRAC_DEPTH-1),
                              $urandom, 17'($urandom_range(0, 65536)), $urandom);
                // Once: hold the sender until every result is back
                if (!paused && items_sent > 200) begin
                    paused = 1'b1;
                    release_input();
                    while (pending_factors.size() != 0) @(posedge i_clk);
                end
            end
            grids_built++;
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, checking on every accepted result
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_factors.size() == 0) begin
                $error("unexpected result: correction_factor %0d interpolated %0d",
                       out_ch.payload.correction_factor, out_ch.payload.interpolated);
                errors++;
            end else begin
                want = pending_factors.pop_front();
                if (out_ch.payload.correction_factor !== want.correction_factor) begin
                    $error("correction_factor: expected %0d, got %0d",
                           want.correction_factor, out_ch.payload.correction_factor);
                    errors++;
                end
                if (out_ch.payload.interpolated !== want.interpolated) begin
                    $error("interpolated: expected %0d, got %0d",
                           want.interpolated, out_ch.payload.interpolated);
                    errors++;
                end
                if (want.interpolated) interp_seen++;
                else                   fallback_seen++;
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        errors = 0; items_sent = 0; queries_sent = 0; interp_seen = 0;
        fallback_seen = 0; grids_built = 0; idle_cycles = 0; calm = 1'b0; stall_left = 0;
        slip_used = SLIP_USED_RESET;
        frac_used = FRAC_USED_RESET;
        for (int k = 0; k < SLIP_DEPTH; k++) slip_pts[k] = '0;
        for (int k = 0; k < FRAC_DEPTH; k++) frac_pts[k] = '0;
        for (int k = 0; k < SLIP_DEPTH*FRAC_DEPTH; k++) factor_cells[k] = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SLIP_USED;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_counts();
        test_min_grid();
        test_max_counts();
        test_random_grids();

        release_input();
        while (pending_factors.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d transactions, %0d queries over %0d random grids",
                 items_sent, queries_sent, grids_built);
        $display("results: %0d interpolated, %0d fallback to one", interp_seen, fallback_seen);
        if (errors == 0 && pending_factors.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
